// ----- rtl/clrs_pkg.sv -----
// Package for the clock replacement set: codes, cell modes, FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package clrs_pkg;

   localparam int ENTRIES_DEFAULT  = 16;
   localparam int KEY_BITS_DEFAULT = 32;
   localparam int KEY_PORT_BITS    = 32;
   localparam int CAP_BITS         = 5;
   localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 5'd16;

   // command codes
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_TOUCH = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_MISS     = 2'd1;
   localparam logic [1:0] STATUS_DISABLED = 2'd2;

   // register indexes
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_ENABLE   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP,
      ST_INSERT
   } state_type;

   typedef enum logic [2:0] {
      CM_HOLD,
      CM_TOUCH,
      CM_CLEAR,
      CM_REMOVE,
      CM_INSERT
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type mode;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ----- rtl/clrs_cell.sv -----
// One slot of the sorted set: key, reference bit, local compare and shift.
// Depends on clrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module clrs_cell #(
   parameter int KEY_BITS = clrs_pkg::KEY_BITS_DEFAULT,
   parameter int ENTRIES  = clrs_pkg::ENTRIES_DEFAULT,
   parameter int IDX      = 0,
   parameter int IW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   parameter int CW       = $clog2(ENTRIES + 1)
) (
   input  wire                     clock,
   input  clrs_pkg::cell_ctl_type  ctl,
   input  wire [IW-1:0]            sel_idx,
   input  wire [CW-1:0]            count,
   input  wire [KEY_BITS-1:0]      key,
   input  wire [KEY_BITS-1:0]      left_key,
   input  wire                     left_lt,
   input  wire                     left_ref,
   input  wire [KEY_BITS-1:0]      right_key,
   input  wire                     right_ref,
   output logic [KEY_BITS-1:0]     key_out,
   output logic                    ref_out,
   output logic                    lt_out,
   output logic                    eq_out
);
   import clrs_pkg::*;

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                ref_ff, ref_in;
   logic                valid;
   logic                hit;

   assign valid  = IDX < int'(count);
   assign hit    = IDX == int'(sel_idx);
   assign lt_out = valid && (key_ff < key);
   assign eq_out = valid && (key_ff == key);
   assign key_out = key_ff;
   assign ref_out = ref_ff;

   // slot update: hold, mark, clear, close a gap, or open one
   always_comb begin
      key_in = key_ff;
      ref_in = ref_ff;
      unique case (ctl.mode)
         CM_HOLD: begin
         end
         CM_TOUCH: begin
            if (eq_out) ref_in = 1'b1;
         end
         CM_CLEAR: begin
            if (hit) ref_in = 1'b0;
         end
         CM_REMOVE: begin
            if (IDX >= int'(sel_idx)) begin
               key_in = right_key;
               ref_in = right_ref;
            end
         end
         CM_INSERT: begin
            if (!lt_out) begin
               if (left_lt) begin
                  key_in = key;
                  ref_in = 1'b1;
               end else begin
                  key_in = left_key;
                  ref_in = left_ref;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      ref_ff <= ref_in;
   end

endmodule
`default_nettype wire

// ----- rtl/clock_replacement_set.sv -----
// Top level of the clock replacement set: control FSM and row of slot cells.
// Depends on clrs_pkg and clrs_cell.
//
// Usage:
//   Command channel: drive req_command / req_key with start high; the beat is
//   taken at a rising edge where busy is low. busy stays high until the
//   result has been issued.
//   Result channel: rsp_strobe is high for one cycle with rsp_status,
//   rsp_evicted and rsp_victim_key. The receiver cannot stall it.
//   Configuration: csr_write with csr_index (0 capacity, 1 enable) and
//   csr_data, taken at once; write only while busy is low.
// Sequence: a touch and a disabled command pass through ST_EXEC before the
//   strobe, an add without eviction through ST_EXEC and then ST_INSERT. An add that
//   evicts walks the clock hand one slot per cycle in ST_SWEEP between those
//   two states. The next command may be accepted in the strobe cycle.
// Storage: a row of ENTRIES cells, each holding one key and its reference
//   bit, shifting to neighbors on insert and remove.
// Reset: empties the set, hand at slot 0, capacity 16, enable 1.
`timescale 1ns / 1ps
`default_nettype none
module clock_replacement_set #(
   parameter int ENTRIES  = clrs_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS = clrs_pkg::KEY_BITS_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire                                req_command,
   input  wire [clrs_pkg::KEY_PORT_BITS-1:0]  req_key,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_evicted,
   output logic [clrs_pkg::KEY_PORT_BITS-1:0] rsp_victim_key,
   input  wire                                csr_write,
   input  wire                                csr_index,
   input  wire [clrs_pkg::CAP_BITS-1:0]       csr_data
);
   import clrs_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   state_type state_ff, state_in;

   logic                cmd_ff, cmd_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [IW-1:0]       hand_ff, hand_in;
   logic [CAP_BITS-1:0] capacity_ff;
   logic                enable_ff;

   logic                strobe_ff, strobe_in;
   logic [1:0]          status_ff, status_in;
   logic                evicted_ff, evicted_in;
   logic [KEY_BITS-1:0] victim_ff, victim_in;

   cell_ctl_type        ctl;
   logic [IW-1:0]       sel_idx;

   logic [KEY_BITS-1:0] cell_key [ENTRIES];
   logic                cell_ref [ENTRIES];
   logic [ENTRIES-1:0]  cell_lt;
   logic [ENTRIES-1:0]  cell_eq;

   logic accept;
   logic any_eq;
   logic full;
   logic set_full;

   assign busy   = state_ff != ST_IDLE;
   assign accept = start && !busy;
   assign any_eq = |cell_eq;
   assign set_full = int'(count_ff) >= ENTRIES;
   assign full   = (count_ff != '0) &&
                   ((int'(count_ff) >= int'(capacity_ff)) || set_full);

   // row of slot cells, each tied to its neighbors
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic [KEY_BITS-1:0] lk, rk;
      logic                llt, lref, rref;
      if (i == 0) begin : g_first
         assign lk   = '0;
         assign lref = 1'b0;
         assign llt  = 1'b1;
      end else begin : g_mid
         assign lk   = cell_key[i-1];
         assign lref = cell_ref[i-1];
         assign llt  = cell_lt[i-1];
      end
      if (i == ENTRIES - 1) begin : g_last
         assign rk   = cell_key[i];
         assign rref = cell_ref[i];
      end else begin : g_inner
         assign rk   = cell_key[i+1];
         assign rref = cell_ref[i+1];
      end
      clrs_cell #(
         .KEY_BITS (KEY_BITS),
         .ENTRIES  (ENTRIES),
         .IDX      (i),
         .IW       (IW),
         .CW       (CW)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .sel_idx   (sel_idx),
         .count     (count_ff),
         .key       (key_ff),
         .left_key  (lk),
         .left_lt   (llt),
         .left_ref  (lref),
         .right_key (rk),
         .right_ref (rref),
         .key_out   (cell_key[i]),
         .ref_out   (cell_ref[i]),
         .lt_out    (cell_lt[i]),
         .eq_out    (cell_eq[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!enable_ff || cmd_ff == CMD_TOUCH) state_in = ST_IDLE;
            else if (full) state_in = ST_SWEEP;
            else state_in = ST_INSERT;
         end
         ST_SWEEP: begin
            if (!cell_ref[hand_ff]) state_in = ST_INSERT;
         end
         ST_INSERT: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control and result
   always_comb begin
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      count_in   = count_ff;
      hand_in    = hand_ff;
      strobe_in  = 1'b0;
      status_in  = status_ff;
      evicted_in = evicted_ff;
      victim_in  = victim_ff;
      ctl.mode   = CM_HOLD;
      sel_idx    = hand_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in     = req_command;
               key_in     = KEY_BITS'(req_key);
               evicted_in = 1'b0;
               victim_in  = '0;
            end
         end
         ST_EXEC: begin
            if (!enable_ff) begin
               strobe_in = 1'b1;
               status_in = STATUS_DISABLED;
            end else if (cmd_ff == CMD_TOUCH) begin
               ctl.mode  = CM_TOUCH;
               strobe_in = 1'b1;
               status_in = any_eq ? STATUS_DONE : STATUS_MISS;
            end else if (full && int'(hand_ff) >= int'(count_ff)) begin
               hand_in = '0;
            end
         end
         ST_SWEEP: begin
            if (cell_ref[hand_ff]) begin
               // second chance: clear and move on
               ctl.mode = CM_CLEAR;
               hand_in  = (int'(hand_ff) + 1 >= int'(count_ff)) ? '0 : IW'(int'(hand_ff) + 1);
            end else begin
               ctl.mode   = CM_REMOVE;
               victim_in  = cell_key[hand_ff];
               evicted_in = 1'b1;
               count_in   = CW'(int'(count_ff) - 1);
               hand_in    = (int'(hand_ff) + 1 < int'(count_ff)) ? hand_ff : '0;
            end
         end
         ST_INSERT: begin
            strobe_in = 1'b1;
            status_in = STATUS_DONE;
            if (!any_eq && !set_full) begin
               ctl.mode = CM_INSERT;
               count_in = CW'(int'(count_ff) + 1);
               if (count_ff == '0) hand_in = '0;
               else if (!cell_lt[hand_ff]) hand_in = IW'(int'(hand_ff) + 1);
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         hand_ff     <= '0;
         strobe_ff   <= 1'b0;
         capacity_ff <= CAPACITY_RESET;
         enable_ff   <= 1'b1;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         hand_ff   <= hand_in;
         strobe_ff <= strobe_in;
         if (csr_write) begin
            unique case (csr_index)
               REG_CAPACITY: capacity_ff <= csr_data;
               REG_ENABLE:   enable_ff   <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      status_ff  <= status_in;
      evicted_ff <= evicted_in;
      victim_ff  <= victim_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_status     = status_ff;
   assign rsp_evicted    = evicted_ff;
   assign rsp_victim_key = KEY_PORT_BITS'(victim_ff);

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= ENTRIES)
      else $error("entry count above depth");

   a_sweep_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (count_ff != '0 && int'(hand_ff) < int'(count_ff)))
      else $error("hand sweep on empty set or hand out of range");

   a_evict_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_evicted) |-> (rsp_status == STATUS_DONE))
      else $error("eviction reported with non-done status");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_EXEC || state_ff == ST_INSERT))
      else $error("result beat without finishing state");
`endif

endmodule
`default_nettype wire
